[sv/textured_column_span_renderer_top_macros.svh]
// Assertion macros for the textured column and span renderer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TEXTURED_COLUMN_SPAN_RENDERER_TOP_MACROS_SVH
`define TEXTURED_COLUMN_SPAN_RENDERER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TCSR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define TCSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCSR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define TCSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[sv/tcsr_pkg.sv]
// Shared types, codes and texture addressing functions for the renderer.
// No dependencies; the frame, shade, control and top modules import this package.
`default_nettype none

package tcsr_pkg;

  localparam int DEF_SCREEN_COLUMNS = 320;
  localparam int DEF_SCREEN_ROWS    = 200;
  localparam int DEF_LIGHT_LEVELS   = 32;
  localparam int TEXTURE_BYTES      = 4096;
  localparam int TEX_AW             = 12;

  localparam logic [31:0] COLUMN_TEX_MASK  = 32'd127;
  localparam logic [31:0] SPAN_ROW_MASK    = 32'h0000_0fc0;
  localparam int          SPAN_X_SHIFT     = 26;
  localparam int          COLUMN_FRAC_BITS = 16;

  typedef enum logic [2:0] {
    FN_NONE      = 3'd0,
    FN_LOAD_CMAP = 3'd1,
    FN_CLEAR     = 3'd2,
    FN_COLUMN    = 3'd3,
    FN_SPAN      = 3'd4,
    FN_READ      = 3'd5,
    FN_LOAD_TEX  = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_SKIPPED = 2'd1,
    STAT_RANGE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DRAW,
    S_DRAIN,
    S_CLEAR,
    S_RD_WAIT,
    S_FINISH
  } state_t;

  // Store writes from load items.
  typedef struct packed {
    logic        cmap_en;
    logic        tex_en;
    logic [15:0] addr;
    logic [7:0]  data;
  } load_wr_t;

  // One pixel issued into the shading pipeline.
  typedef struct packed {
    logic              valid;
    logic [TEX_AW-1:0] tex_addr;
  } pix_t;

  // Framebuffer write strobe and byte.
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } fb_wr_t;

  // Column texel: bits 22..16 of the 16.16 position.
  function automatic logic [TEX_AW-1:0] tex_col_addr(input logic [31:0] pos);
    return TEX_AW'((pos >> COLUMN_FRAC_BITS) & COLUMN_TEX_MASK);
  endfunction

  // Span texel: texture y from bits 15..10 selects a 64-byte row, x from the top six bits.
  function automatic logic [TEX_AW-1:0] tex_span_addr(input logic [31:0] pos);
    return TEX_AW'(((pos >> 4) & SPAN_ROW_MASK) | (pos >> SPAN_X_SHIFT));
  endfunction

endpackage

`default_nettype wire

[sv/tcsr_in_if.sv]
// Input channel of the renderer: valid/ready handshake with the item fields.
// No dependencies.
`default_nettype none

interface tcsr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] address;
  logic [7:0]  data;
  logic [4:0]  light_level;
  logic [15:0] x_start;
  logic [15:0] x_end;
  logic [15:0] y_start;
  logic [15:0] y_end;
  logic [31:0] position;
  logic [31:0] step;

  modport source(output valid, func, address, data, light_level, x_start, x_end,
                 y_start, y_end, position, step, input ready);
  modport sink(input valid, func, address, data, light_level, x_start, x_end,
               y_start, y_end, position, step, output ready);
endinterface

`default_nettype wire

[sv/tcsr_out_if.sv]
// Result channel of the renderer: valid/ready handshake with read data and status.
// No dependencies.
`default_nettype none

interface tcsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] status;

  modport source(output valid, read_data, status, input ready);
  modport sink(input valid, read_data, status, output ready);
endinterface

`default_nettype wire

[sv/tcsr_frame.sv]
// Framebuffer memory: one write port shared by the clear sweep and the draw
// pipeline, one registered read port. Depends on tcsr_pkg.
`default_nettype none

module tcsr_frame
  import tcsr_pkg::*;
#(
  parameter int FB_DEPTH = DEF_SCREEN_COLUMNS * DEF_SCREEN_ROWS,
  parameter int FB_AW    = $clog2(FB_DEPTH)
) (
  input  wire logic             clk,
  input  wire fb_wr_t           clr,
  input  wire logic [FB_AW-1:0] clr_addr,
  input  wire fb_wr_t           draw,
  input  wire logic [FB_AW-1:0] draw_addr,
  input  wire logic [FB_AW-1:0] rd_addr,
  output logic [7:0]            rd_data
);

  logic [7:0] mem [FB_DEPTH];

  always_ff @(posedge clk) begin
    if (clr.en) begin
      mem[clr_addr] <= clr.data;
    end else if (draw.en) begin
      mem[draw_addr] <= draw.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[sv/tcsr_shade.sv]
// Texture and colormap memories with the two-stage texel fetch and shade
// pipeline that feeds the framebuffer. Depends on tcsr_pkg.
`default_nettype none

module tcsr_shade
  import tcsr_pkg::*;
#(
  parameter int LIGHT_LEVELS = DEF_LIGHT_LEVELS,
  parameter int FB_AW        = $clog2(DEF_SCREEN_COLUMNS * DEF_SCREEN_ROWS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire load_wr_t         ld,
  input  wire pix_t             pix,
  input  wire logic [FB_AW-1:0] pix_fb_addr,
  input  wire logic [4:0]       light,
  output fb_wr_t                wr,
  output logic [FB_AW-1:0]      wr_addr,
  output logic                  busy
);

  localparam int CMAP_DEPTH = LIGHT_LEVELS * 256;
  localparam int CMAP_AW    = $clog2(CMAP_DEPTH);

  logic [7:0] tex_mem  [TEXTURE_BYTES];
  logic [7:0] cmap_mem [CMAP_DEPTH];

  logic [7:0]         tex_q;
  logic [7:0]         cmap_q;
  logic               s1_v;
  logic               s2_v;
  logic [FB_AW-1:0]   s1_addr;
  logic [FB_AW-1:0]   s2_addr;
  logic [CMAP_AW-1:0] cmap_rd_addr;

  // Light is already saturated below LIGHT_LEVELS, so row*256+texel stays in range.
  assign cmap_rd_addr = CMAP_AW'({light, tex_q});

  always_ff @(posedge clk) begin
    if (ld.tex_en) begin
      tex_mem[ld.addr[TEX_AW-1:0]] <= ld.data;
    end
    if (ld.cmap_en) begin
      cmap_mem[CMAP_AW'(ld.addr)] <= ld.data;
    end
    tex_q   <= tex_mem[pix.tex_addr];
    cmap_q  <= cmap_mem[cmap_rd_addr];
    s1_addr <= pix_fb_addr;
    s2_addr <= s1_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= pix.valid;
      s2_v <= s1_v;
    end
  end

  assign wr.en   = s2_v;
  assign wr.data = cmap_q;
  assign wr_addr = s2_addr;
  assign busy    = s1_v | s2_v;

endmodule

`default_nettype wire

[sv/tcsr_ctrl.sv]
// Item sequencer: decodes items, clips draws, steps the texture position,
// sweeps the framebuffer clear and holds the result register.
// Depends on tcsr_pkg, the channel interfaces and the assertion macros.
`default_nettype none
`include "textured_column_span_renderer_top_macros.svh"

module tcsr_ctrl
  import tcsr_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
  parameter int LIGHT_LEVELS   = DEF_LIGHT_LEVELS,
  parameter int FB_AW          = $clog2(SCREEN_COLUMNS * SCREEN_ROWS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  tcsr_in_if.sink               req,
  tcsr_out_if.source            rsp,
  output load_wr_t              ld,
  output pix_t                  pix,
  output logic [FB_AW-1:0]      pix_fb_addr,
  output logic [4:0]            light,
  output fb_wr_t                clr,
  output logic [FB_AW-1:0]      clr_addr,
  output logic [FB_AW-1:0]      rd_addr,
  input  wire logic [7:0]       rd_data,
  input  wire logic             pipe_busy
);

  localparam int XW       = $clog2(SCREEN_COLUMNS);
  localparam int YW       = $clog2(SCREEN_ROWS);
  localparam int CW       = (XW > YW) ? XW : YW;
  localparam int FB_DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam logic [31:0] CMAP_DEPTH_W = 32'(LIGHT_LEVELS * 256);
  localparam logic [31:0] FB_DEPTH_W   = 32'(FB_DEPTH);
  localparam logic [31:0] TEX_DEPTH_W  = 32'(TEXTURE_BYTES);

  state_t      state;
  state_t      state_next;
  func_t       fn_q;
  logic [4:0]  light_q;
  logic [15:0] xs_q;
  logic [15:0] xe_q;
  logic [15:0] ys_q;
  logic [15:0] ye_q;
  logic [31:0] pos_q;
  logic [31:0] step_q;
  logic [FB_AW-1:0] fb_addr;
  logic [FB_AW-1:0] inc;
  logic [CW-1:0]    cnt;
  logic [FB_AW-1:0] clr_cnt;
  logic [7:0]  res_data;
  status_t     res_status;
  logic        out_valid;
  logic [7:0]  out_data;
  status_t     out_status;

  logic        accept;
  func_t       in_func;
  logic [31:0] addr32;
  logic        cmap_ok;
  logic        tex_ok;
  logic        fb_ok;
  status_t     in_status;
  logic [4:0]  light_sat;
  logic        fin_load;

  logic              is_col;
  logic [YW-1:0]     y0c;
  logic [YW-1:0]     y1c;
  logic [XW-1:0]     x0c;
  logic [XW-1:0]     x1c;
  logic [YW-1:0]     row;
  logic [XW-1:0]     col;
  logic [FB_AW-1:0]  base;
  logic [CW-1:0]     count;
  logic              skip;

  assign accept  = req.valid && req.ready;
  assign in_func = func_t'(req.func);
  assign addr32  = {16'd0, req.address};
  assign cmap_ok = addr32 < CMAP_DEPTH_W;
  assign tex_ok  = addr32 < TEX_DEPTH_W;
  assign fb_ok   = addr32 < FB_DEPTH_W;
  assign light_sat = (32'(req.light_level) >= 32'(LIGHT_LEVELS)) ?
                     5'(LIGHT_LEVELS - 1) : req.light_level;

  always_comb begin
    unique case (in_func)
      FN_LOAD_CMAP: in_status = cmap_ok ? STAT_DONE : STAT_RANGE;
      FN_LOAD_TEX:  in_status = tex_ok ? STAT_DONE : STAT_RANGE;
      FN_READ:      in_status = fb_ok ? STAT_DONE : STAT_RANGE;
      default:      in_status = STAT_DONE;
    endcase
  end

  // Load items write their store on the accepting edge.
  assign ld.cmap_en = accept && (in_func == FN_LOAD_CMAP) && cmap_ok;
  assign ld.tex_en  = accept && (in_func == FN_LOAD_TEX) && tex_ok;
  assign ld.addr    = req.address;
  assign ld.data    = req.data;
  assign rd_addr    = FB_AW'(req.address);

  // Clipping and the starting framebuffer address of a draw.
  assign is_col = (fn_q == FN_COLUMN);
  assign y0c = (ys_q >= 16'(SCREEN_ROWS)) ? YW'(SCREEN_ROWS - 1) : YW'(ys_q);
  assign y1c = (ye_q >= 16'(SCREEN_ROWS)) ? YW'(SCREEN_ROWS - 1) : YW'(ye_q);
  assign x0c = (xs_q >= 16'(SCREEN_COLUMNS)) ? XW'(SCREEN_COLUMNS - 1) : XW'(xs_q);
  assign x1c = (xe_q >= 16'(SCREEN_COLUMNS)) ? XW'(SCREEN_COLUMNS - 1) : XW'(xe_q);
  assign row   = is_col ? y0c : YW'(ys_q);
  assign col   = is_col ? XW'(xs_q) : x0c;
  assign base  = FB_AW'(row) * FB_AW'(SCREEN_COLUMNS) + FB_AW'(col);
  assign count = is_col ? CW'(y1c - y0c) : CW'(x1c - x0c);
  assign skip  = is_col ? ((xs_q >= 16'(SCREEN_COLUMNS)) || (y0c > y1c))
                        : ((ys_q >= 16'(SCREEN_ROWS)) || (x0c > x1c));

  assign fin_load = (state == S_FINISH) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func) inside
            FN_CLEAR:          state_next = S_CLEAR;
            FN_COLUMN, FN_SPAN: state_next = S_SETUP;
            FN_READ:           state_next = fb_ok ? S_RD_WAIT : S_FINISH;
            default:           state_next = S_FINISH;
          endcase
        end
      end
      S_SETUP:   state_next = skip ? S_FINISH : S_DRAW;
      S_DRAW:    state_next = (cnt == '0) ? S_DRAIN : S_DRAW;
      S_DRAIN:   state_next = pipe_busy ? S_DRAIN : S_FINISH;
      S_CLEAR:   state_next = (clr_cnt == FB_AW'(FB_DEPTH - 1)) ? S_FINISH : S_CLEAR;
      S_RD_WAIT: state_next = S_FINISH;
      S_FINISH:  state_next = fin_load ? S_IDLE : S_FINISH;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fn_q       <= in_func;
      light_q    <= light_sat;
      xs_q       <= req.x_start;
      xe_q       <= req.x_end;
      ys_q       <= req.y_start;
      ye_q       <= req.y_end;
      pos_q      <= req.position;
      step_q     <= req.step;
      res_data   <= 8'd0;
      res_status <= in_status;
      clr_cnt    <= '0;
    end
    case (state)
      S_SETUP: begin
        fb_addr <= base;
        cnt     <= count;
        inc     <= is_col ? FB_AW'(SCREEN_COLUMNS) : FB_AW'(1);
        if (skip) begin
          res_status <= STAT_SKIPPED;
        end
      end
      S_DRAW: begin
        pos_q   <= pos_q + step_q;
        fb_addr <= fb_addr + inc;
        cnt     <= cnt - CW'(1);
      end
      S_CLEAR:   clr_cnt  <= clr_cnt + FB_AW'(1);
      S_RD_WAIT: res_data <= rd_data;
      default: ;
    endcase
  end

  // The result register lets the next item in while this beat waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data   <= res_data;
      out_status <= res_status;
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;
  assign rsp.status    = out_status;

  assign pix.valid    = (state == S_DRAW);
  assign pix.tex_addr = is_col ? tex_col_addr(pos_q) : tex_span_addr(pos_q);
  assign pix_fb_addr  = fb_addr;
  assign light        = light_q;
  assign clr.en       = (state == S_CLEAR);
  assign clr.data     = 8'd0;
  assign clr_addr     = clr_cnt;

  `TCSR_ASSERT_NOW(a_pipe_only_in_draw, clk, rst, pipe_busy,
                   state == S_DRAW || state == S_DRAIN, "shade pipeline active outside a draw")
  `TCSR_ASSERT_NOW(a_clear_alone, clk, rst, state == S_CLEAR, !pipe_busy,
                   "clear sweep overlaps draw writes")
  `TCSR_ASSERT_NOW(a_draw_addr_range, clk, rst, state == S_DRAW, 32'(fb_addr) < FB_DEPTH_W,
                   "draw address beyond framebuffer")
  `TCSR_ASSERT_NEXT(a_read_one_cycle, clk, rst, state == S_RD_WAIT, state == S_FINISH,
                    "framebuffer read did not complete")

endmodule

`default_nettype wire

[sv/textured_column_span_renderer_top.sv]
// Top level of the textured column and span renderer.
// Depends on tcsr_pkg, tcsr_in_if, tcsr_out_if, tcsr_frame, tcsr_shade, tcsr_ctrl.
//
//   channel | direction | beat carries
//   req     | in        | func, address, data, light_level, x/y bounds, position, step
//   rsp     | out       | read_data, status (one beat per req beat)
//
// A draw sends its pixels one a cycle through texture then colormap memory and
// writes nothing when clipped away; a clear writes all SCREEN_COLUMNS *
// SCREEN_ROWS framebuffer bytes, one framebuffer byte a cycle. One item is
// worked on at a time; a finished beat waits in the result register while the
// next item is taken, and the next item stalls in its finish state while that
// beat is still waiting. Reset clears control state only; the stores hold
// nothing defined until loaded, cleared or drawn.
`default_nettype none

module textured_column_span_renderer_top
  import tcsr_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
  parameter int LIGHT_LEVELS   = DEF_LIGHT_LEVELS
) (
  input wire logic   clk,
  input wire logic   rst,
  tcsr_in_if.sink    req,
  tcsr_out_if.source rsp
);

  localparam int FB_DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int FB_AW    = $clog2(FB_DEPTH);

  load_wr_t         ld;
  pix_t             pix;
  logic [FB_AW-1:0] pix_fb_addr;
  logic [4:0]       light;
  fb_wr_t           clr;
  logic [FB_AW-1:0] clr_addr;
  fb_wr_t           draw;
  logic [FB_AW-1:0] draw_addr;
  logic [FB_AW-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             pipe_busy;

  tcsr_ctrl #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .LIGHT_LEVELS   (LIGHT_LEVELS),
    .FB_AW          (FB_AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .ld          (ld),
    .pix         (pix),
    .pix_fb_addr (pix_fb_addr),
    .light       (light),
    .clr         (clr),
    .clr_addr    (clr_addr),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .pipe_busy   (pipe_busy)
  );

  tcsr_shade #(
    .LIGHT_LEVELS (LIGHT_LEVELS),
    .FB_AW        (FB_AW)
  ) u_shade (
    .clk         (clk),
    .rst         (rst),
    .ld          (ld),
    .pix         (pix),
    .pix_fb_addr (pix_fb_addr),
    .light       (light),
    .wr          (draw),
    .wr_addr     (draw_addr),
    .busy        (pipe_busy)
  );

  tcsr_frame #(
    .FB_DEPTH (FB_DEPTH),
    .FB_AW    (FB_AW)
  ) u_frame (
    .clk       (clk),
    .clr       (clr),
    .clr_addr  (clr_addr),
    .draw      (draw),
    .draw_addr (draw_addr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

endmodule

`default_nettype wire
